>>> sv/rdu_pkg.sv
// Package for the reversible deque unit: sizes, command and result codes,
// item structs and the circular index helper.
// Depends on nothing; every other file refers to it by scoped names.
package rdu_pkg;

  // Store geometry.
  localparam int DEPTH      = 32;
  localparam int VALUE_BITS = 8;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Command queue between front and back (power of two entries).
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input command codes.
  localparam logic [2:0] CMD_PUSH    = 3'd0;
  localparam logic [2:0] CMD_REVERSE = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  // Result kind codes.
  localparam logic [1:0] KIND_ELEM  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] element;
    logic       last;
  } out_item_t;

  // Decoded operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_PUSH,
    OP_REVERSE,
    OP_DELETE,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [VALUE_BITS-1:0] value;
  } op_item_t;

  // Circular add of an offset (at most DEPTH) to a store index.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    begin
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
        sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
    end
  endfunction

endpackage

>>> sv/rdu_front.sv
// Front end of the reversible deque unit: accepts input items, decodes the
// command and queues meaningful operations. Depends on rdu_pkg.
module rdu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rdu_pkg::in_item_t   in_data,
  input  logic                q_full,
  output logic                q_push,
  output rdu_pkg::op_item_t   q_item
);

  logic        keep;
  logic [31:0] value_wide;
  logic        busy_r;

  // Hold off input right after reset so the queue settles.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign in_ready = !q_full && !busy_r;

  // Only the low store-width bits of the value are kept.
  assign value_wide = 32'(in_data.value);

  // Decode the command; undefined codes are dropped here.
  always_comb begin
    keep         = 1'b1;
    q_item.op    = rdu_pkg::OP_PUSH;
    q_item.value = value_wide[rdu_pkg::VALUE_BITS-1:0];
    case (in_data.command)
      rdu_pkg::CMD_PUSH:    q_item.op = rdu_pkg::OP_PUSH;
      rdu_pkg::CMD_REVERSE: q_item.op = rdu_pkg::OP_REVERSE;
      rdu_pkg::CMD_DELETE:  q_item.op = rdu_pkg::OP_DELETE;
      rdu_pkg::CMD_READ:    q_item.op = rdu_pkg::OP_READ;
      rdu_pkg::CMD_CLEAR:   q_item.op = rdu_pkg::OP_CLEAR;
      default:              keep      = 1'b0;
    endcase
  end

  assign q_push = in_valid && in_ready && keep;

endmodule

>>> sv/rdu_queue.sv
// Short operation queue between the front and the back of the deque unit.
// Depends on rdu_pkg.
module rdu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rdu_pkg::op_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output rdu_pkg::op_item_t pop_item
);

  rdu_pkg::op_item_t               entries_r [rdu_pkg::QDEPTH];
  logic [rdu_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [rdu_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [rdu_pkg::QCNT_W-1:0]      cnt_r;

  assign full     = (cnt_r == rdu_pkg::QCNT_W'(rdu_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = entries_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> sv/rdu_back.sv
// Back end of the reversible deque unit: holds the circular store and the
// deque state, executes queued operations and streams readouts.
// Depends on rdu_pkg.
module rdu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  rdu_pkg::op_item_t  q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output rdu_pkg::out_item_t out_data
);

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  logic [rdu_pkg::VALUE_BITS-1:0] mem [rdu_pkg::DEPTH];
  logic [rdu_pkg::VALUE_BITS-1:0] rdata_r;

  state_t                    state_r;
  logic [rdu_pkg::PTR_W-1:0] front_r;
  logic [rdu_pkg::CNT_W-1:0] count_r;
  logic                      rev_r;
  logic                      err_r;
  logic [rdu_pkg::CNT_W-1:0] idx_r;
  logic                      p1_valid_r;
  logic [1:0]                p1_kind_r;
  logic                      p1_last_r;
  logic                      out_valid_r;
  rdu_pkg::out_item_t        out_data_r;

  logic                      out_move;
  logic                      p1_free;
  logic                      p1_load;
  logic                      issue_read;
  logic                      full;
  logic                      read_last;
  logic                      we;
  logic [rdu_pkg::CNT_W-1:0] rd_off;
  logic [rdu_pkg::PTR_W-1:0] rd_addr;
  logic [rdu_pkg::PTR_W-1:0] wr_addr;
  logic [31:0]               rdata_wide;
  logic [7:0]                p1_elem;

  // Handshake between the read stage, the output register and the queue.
  assign out_move   = !out_valid_r || out_ready;
  assign p1_free    = !p1_valid_r || out_move;
  assign issue_read = (state_r == ST_READ) && p1_free;
  assign q_pop      = (state_r == ST_IDLE) && !q_empty &&
                      ((q_item.op != rdu_pkg::OP_READ) || p1_free);
  assign full       = (count_r == rdu_pkg::CNT_W'(rdu_pkg::DEPTH));
  assign read_last  = (idx_r == count_r - 1'b1);

  // The read stage loads on a store read or on a single empty or error result.
  assign p1_load = issue_read ||
                   (q_pop && (q_item.op == rdu_pkg::OP_READ) &&
                    (err_r || (count_r == '0)));

  // Store addressing: pushes go behind the tail, reads walk in current order.
  assign rd_off  = rev_r ? (count_r - 1'b1 - idx_r) : idx_r;
  assign rd_addr = rdu_pkg::wrap_add(front_r, rd_off);
  assign wr_addr = rdu_pkg::wrap_add(front_r, count_r);
  assign we      = q_pop && (q_item.op == rdu_pkg::OP_PUSH) && !full;

  // Circular store with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= q_item.value;
    end
    if (issue_read) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign rdata_wide = 32'(rdata_r);
  assign p1_elem    = (p1_kind_r == rdu_pkg::KIND_ELEM) ? rdata_wide[7:0] : 8'd0;

  // Deque state, readout sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      err_r       <= 1'b0;
      idx_r       <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Output register takes the read stage whenever it is free.
      if (out_move) begin
        out_valid_r <= p1_valid_r;
        if (p1_valid_r) begin
          out_data_r.kind    <= p1_kind_r;
          out_data_r.element <= p1_elem;
          out_data_r.last    <= p1_last_r;
        end
      end

      // Read stage occupancy.
      if (p1_load) begin
        p1_valid_r <= 1'b1;
      end else if (out_move) begin
        p1_valid_r <= 1'b0;
      end

      // One element of a readout per free slot.
      if (issue_read) begin
        p1_kind_r <= rdu_pkg::KIND_ELEM;
        p1_last_r <= read_last;
        idx_r     <= idx_r + 1'b1;
        if (read_last) begin
          state_r <= ST_IDLE;
        end
      end

      // Execute the operation at the head of the queue.
      if (q_pop) begin
        case (q_item.op)
          rdu_pkg::OP_PUSH: begin
            if (full) begin
              err_r <= 1'b1;
            end else begin
              count_r <= count_r + 1'b1;
            end
          end
          rdu_pkg::OP_REVERSE: begin
            rev_r <= !rev_r;
          end
          rdu_pkg::OP_DELETE: begin
            if (!err_r) begin
              if (count_r == '0) begin
                err_r <= 1'b1;
              end else begin
                count_r <= count_r - 1'b1;
                if (!rev_r) begin
                  front_r <= rdu_pkg::wrap_add(front_r, rdu_pkg::CNT_W'(1));
                end
              end
            end
          end
          rdu_pkg::OP_READ: begin
            if (err_r) begin
              p1_kind_r <= rdu_pkg::KIND_ERROR;
              p1_last_r <= 1'b1;
            end else if (count_r == '0) begin
              p1_kind_r <= rdu_pkg::KIND_EMPTY;
              p1_last_r <= 1'b1;
            end else begin
              state_r <= ST_READ;
              idx_r   <= '0;
            end
          end
          rdu_pkg::OP_CLEAR: begin
            front_r <= '0;
            count_r <= '0;
            rev_r   <= 1'b0;
            err_r   <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/reversible_deque_unit.sv
// Top level of the reversible deque unit: front decoder, operation queue
// and back end. Depends on rdu_pkg, rdu_front, rdu_queue and rdu_back.
//
//   Channel  Ports                           Item
//   input    in_valid, in_ready, in_data     command, value
//   result   out_valid, out_ready, out_data  kind, element, last
//
// A readout of n elements makes one store read per element; an empty or error
// readout makes no store read.
// While a readout streams, the two-entry queue keeps accepting items until full.
// Reset is synchronous and active low; input is held off in the cycle after it.
// A stalled result holds in the output register; one more waits in the read stage.
module reversible_deque_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rdu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rdu_pkg::out_item_t out_data
);

  logic              q_full;
  logic              q_push;
  logic              q_empty;
  logic              q_pop;
  rdu_pkg::op_item_t q_push_item;
  rdu_pkg::op_item_t q_pop_item;

  // Decode and queue incoming items.
  rdu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  // Operation queue.
  rdu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (q_pop_item)
  );

  // Execute operations and stream results.
  rdu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_pop_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> tb/sv/reversible_deque_unit_test.sv
// Self-checking testbench for reversible_deque_unit: a directed table, then random
// command sequences checked against a shadow deque kept in the testbench.
// Depends on rdu_pkg and the reversible_deque_unit RTL.
module reversible_deque_unit_test;

  localparam int RAND_OPS     = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  rdu_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  rdu_pkg::out_item_t out_data;

  reversible_deque_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the deque, advanced once per accepted item.
  logic [7:0]                dq_store [rdu_pkg::DEPTH];
  logic [rdu_pkg::PTR_W-1:0] dq_head;
  logic [rdu_pkg::CNT_W-1:0] dq_count;
  logic                      dq_rev;
  logic                      dq_err;
  rdu_pkg::out_item_t        step_out [$];

  // Results the block still owes, oldest first.
  rdu_pkg::out_item_t due_results [$];

  // One row of the directed table; want is used only when typed is set.
  typedef struct {
    rdu_pkg::in_item_t  stim;
    logic               typed;
    rdu_pkg::out_item_t want;
  } dir_row_t;
  dir_row_t dir_rows [$];

  int   mismatches  = 0;
  int   cycle_count = 0;
  int   op_count    = 0;
  int   burst_left  = 0;
  logic hold_req    = 1'b0;

  function automatic rdu_pkg::out_item_t make_result(input logic [1:0] kind,
                                                     input logic [7:0] element,
                                                     input logic is_last);
    rdu_pkg::out_item_t r;
    r.kind    = kind;
    r.element = element;
    r.last    = is_last;
    return r;
  endfunction

  // Apply one command to the shadow deque and collect the readout it causes.
  function automatic void deque_model_step(input rdu_pkg::in_item_t it);
    int pos;
    int cnt;
    step_out.delete();
    cnt = int'(dq_count);
    case (it.command)
      rdu_pkg::CMD_PUSH: begin
        if (cnt >= rdu_pkg::DEPTH) begin
          dq_err = 1'b1;
        end else begin
          dq_store[(int'(dq_head) + cnt) % rdu_pkg::DEPTH] = it.value;
          dq_count = dq_count + 1'b1;
        end
      end
      rdu_pkg::CMD_REVERSE: begin
        dq_rev = ~dq_rev;
      end
      rdu_pkg::CMD_DELETE: begin
        // A sticky error blocks deletes until the next clear.
        if (!dq_err) begin
          if (cnt == 0) begin
            dq_err = 1'b1;
          end else begin
            if (!dq_rev) begin
              dq_head = rdu_pkg::PTR_W'((int'(dq_head) + 1) % rdu_pkg::DEPTH);
            end
            dq_count = dq_count - 1'b1;
          end
        end
      end
      rdu_pkg::CMD_READ: begin
        if (dq_err) begin
          step_out.push_back(make_result(rdu_pkg::KIND_ERROR, 8'h00, 1'b1));
        end else if (cnt == 0) begin
          step_out.push_back(make_result(rdu_pkg::KIND_EMPTY, 8'h00, 1'b1));
        end else begin
          for (int k = 0; k < cnt; k++) begin
            pos = dq_rev ? int'(dq_head) + cnt - 1 - k : int'(dq_head) + k;
            step_out.push_back(make_result(rdu_pkg::KIND_ELEM,
                                           dq_store[pos % rdu_pkg::DEPTH], k + 1 == cnt));
          end
        end
      end
      rdu_pkg::CMD_CLEAR: begin
        dq_head  = '0;
        dq_count = '0;
        dq_rev   = 1'b0;
        dq_err   = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  // Offer one item, honoring the burst and gap pattern, and record what it owes.
  task automatic offer(input rdu_pkg::in_item_t it, input logic typed,
                       input rdu_pkg::out_item_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_ready !== 1'b1) begin
      @(posedge clk);
    end
    deque_model_step(it);
    if (typed) begin
      due_results.push_back(want);
    end else begin
      foreach (step_out[i]) begin
        due_results.push_back(step_out[i]);
      end
    end
  endtask

  task automatic send_op(input logic [2:0] cmd, input logic [7:0] val);
    rdu_pkg::in_item_t it;
    it.command = cmd;
    it.value   = val;
    offer(it, 1'b0, make_result(rdu_pkg::KIND_ELEM, 8'h00, 1'b0));
    op_count++;
  endtask

  task automatic add_row(input logic [2:0] cmd, input logic [7:0] val, input logic typed,
                         input logic [1:0] kind, input logic [7:0] element,
                         input logic want_last);
    dir_row_t row;
    row.stim.command = cmd;
    row.stim.value   = val;
    row.typed        = typed;
    row.want         = make_result(kind, element, want_last);
    dir_rows.push_back(row);
  endtask

  // Clear, fill to around capacity (sometimes past it), maybe reverse, then read back, trim and read again.
  task automatic fill_run();
    int n;
    send_op(rdu_pkg::CMD_CLEAR, 8'($urandom));
    n = $urandom_range(rdu_pkg::DEPTH - 2, rdu_pkg::DEPTH + 3);
    repeat (n) send_op(rdu_pkg::CMD_PUSH, 8'($urandom));
    if ($urandom_range(0, 1) == 1) begin
      send_op(rdu_pkg::CMD_REVERSE, 8'($urandom));
    end
    send_op(rdu_pkg::CMD_READ, 8'($urandom));
    repeat ($urandom_range(0, 4)) send_op(rdu_pkg::CMD_DELETE, 8'($urandom));
    send_op(rdu_pkg::CMD_READ, 8'($urandom));
  endtask

  // Main sequence: reset, directed table, random traffic, drain.
  initial begin
    int r;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    foreach (dq_store[i]) begin
      dq_store[i] = '0;
    end
    dq_head  = '0;
    dq_count = '0;
    dq_rev   = 1'b0;
    dq_err   = 1'b0;

    //      command               value  typed kind                element last
    add_row(rdu_pkg::CMD_READ,    8'h00, 1'b1, rdu_pkg::KIND_EMPTY, 8'h00, 1'b1);
    add_row(rdu_pkg::CMD_PUSH,    8'h00, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_PUSH,    8'hFF, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_PUSH,    8'hA5, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_READ,    8'h00, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_REVERSE, 8'h00, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_READ,    8'hFF, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_DELETE,  8'h00, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_READ,    8'h00, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_REVERSE, 8'hFF, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_DELETE,  8'hFF, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_READ,    8'h00, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_DELETE,  8'h00, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_DELETE,  8'h00, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_READ,    8'h00, 1'b1, rdu_pkg::KIND_ERROR, 8'h00, 1'b1);
    add_row(rdu_pkg::CMD_DELETE,  8'h00, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_PUSH,    8'h33, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_REVERSE, 8'h00, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_READ,    8'h00, 1'b1, rdu_pkg::KIND_ERROR, 8'h00, 1'b1);
    add_row(rdu_pkg::CMD_CLEAR + 3'd1, 8'h55, 1'b0, rdu_pkg::KIND_ELEM, 8'h00, 1'b0);
    add_row(3'b111,               8'hFF, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_CLEAR,   8'hAA, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_PUSH,    8'h3C, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_READ,    8'h00, 1'b1, rdu_pkg::KIND_ELEM,  8'h3C, 1'b1);
    add_row(rdu_pkg::CMD_CLEAR,   8'h00, 1'b0, rdu_pkg::KIND_ELEM,  8'h00, 1'b0);
    add_row(rdu_pkg::CMD_READ,    8'h00, 1'b1, rdu_pkg::KIND_EMPTY, 8'h00, 1'b1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    end

    // The receiver starts its one long hold-off as the first fill begins, so the block backs up.
    hold_req = 1'b1;
    op_count = 0;
    fill_run();
    while (op_count < RAND_OPS) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        fill_run();
      end else if (r <= 2) begin
        send_op(3'($urandom_range(int'(rdu_pkg::CMD_CLEAR) + 1, 7)), 8'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (dq_err && r < 30) begin
          send_op(rdu_pkg::CMD_CLEAR, 8'($urandom));
        end else if (r < 45) begin
          send_op(rdu_pkg::CMD_PUSH, 8'($urandom));
        end else if (r < 55) begin
          send_op(rdu_pkg::CMD_REVERSE, 8'($urandom));
        end else if (r < 72) begin
          send_op(rdu_pkg::CMD_DELETE, 8'($urandom));
        end else if (r < 92) begin
          send_op(rdu_pkg::CMD_READ, 8'($urandom));
        end else begin
          send_op(rdu_pkg::CMD_CLEAR, 8'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    while (due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: runs of always-ready, random, periodic and sparse acceptance,
  // plus one long hold-off when the random traffic starts.
  initial begin
    int   mode;
    int   run_left;
    int   phase;
    logic hold_done;
    logic rdy;
    out_ready = 1'b0;
    run_left  = 0;
    phase     = 0;
    hold_done = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 3);
          run_left = $urandom_range(10, 60);
        end
        run_left--;
        phase++;
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = (phase % 4) != 3;
          default: rdy = ($urandom_range(0, 5) == 0);
        endcase
        out_ready <= rdy;
        @(posedge clk);
      end
    end
  end

  // Compare every accepted result with the oldest one still owed.
  always @(posedge clk) begin : check_results
    rdu_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d element %0h last %0b",
               out_data.kind, out_data.element, out_data.last);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          mismatches++;
        end
        if (out_data.element !== want.element) begin
          $error("element: expected %0h, got %0h", want.element, out_data.element);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
